>>> rtl/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg: shared types and constants
// Payload structs, register indexes, reset values and divider sizing for the
// columnar transposition cipher.
// ----------------------------------------------------------------------------
package cct_pkg;

  localparam int POS_W       = 10;
  localparam int CHAR_W      = 8;
  localparam int COUNT_W     = 4;
  localparam int LEN_W       = 10;
  localparam int KEY_W       = 24;
  localparam int KEY_ENTRIES = 8;
  localparam int KEY_ENT_W   = 3;
  localparam int MAX_COLUMNS = 8;
  localparam int CALC_W      = 14;

  // Shared divider: two quotient bits per cycle
  localparam int DIV_W      = 10;
  localparam int DIV_DIGITS = 2;
  localparam int DIV_ITER   = DIV_W / DIV_DIGITS;
  localparam int DIV_CNT_W  = $clog2(DIV_ITER);

  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLUMN_LENGTH   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_PERMUTATION = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_ENCRYPT_MODE    = 2'd3;

  localparam logic [COUNT_W-1:0] COLUMN_COUNT_RST  = 4'd2;
  localparam logic [LEN_W-1:0]   COLUMN_LENGTH_RST = 10'd1;
  localparam logic [KEY_W-1:0]   KEY_RST           = 24'hFAC688;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] char_in;
  } cct_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              out_of_range;
  } cct_out_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] reg_index;
    logic [KEY_W-1:0]     reg_data;
  } cct_cfg_t;

endpackage

>>> rtl/cct_cfg_if.sv
// ----------------------------------------------------------------------------
// cct_cfg_if: configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cct_cfg_if;
  logic              valid;
  logic              ready;
  cct_pkg::cct_cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/cct_in_if.sv
// ----------------------------------------------------------------------------
// cct_in_if: request channel
// Write or read request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cct_in_if;
  logic             valid;
  logic             ready;
  cct_pkg::cct_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/cct_out_if.sv
// ----------------------------------------------------------------------------
// cct_out_if: result channel
// One result byte and range flag per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cct_out_if;
  logic              valid;
  logic              ready;
  cct_pkg::cct_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/columnar_transposition_cipher.sv
// ----------------------------------------------------------------------------
// columnar_transposition_cipher: transposition read-out engine
// Holds one message and returns bytes of its transposed form on request.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i  - register writes (column count, column length, key, mode); always
//            ready, write only while no request is outstanding.
//   in_i   - requests: func 0 writes char_in at position, func 1 reads the
//            transformed byte at output position.
//   out_o  - one result per request, held in an output register.
// Sequence: a write or an out-of-range read goes from idle straight to the
//   done state; an in-range read passes through the divider (two quotient
//   bits per step), the address register, the buffer read and the load.
// Flow: one request is in flight at a time; in_i is ready only in idle, so
//   a new request is taken only after the last one has loaded its result.
// Reset: registers return to 2 columns, length 1, identity key, decrypt;
//   buffer contents are undefined until written.
// Stall: a result waits in the output register while the next request is
//   taken; the engine then holds its finished result until out_o is free.
// ----------------------------------------------------------------------------
module columnar_transposition_cipher #(
  parameter int MAX_TEXT = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cct_cfg_if.sink   cfg_i,
  cct_in_if.sink    in_i,
  cct_out_if.source out_o
);
  import cct_pkg::*;

  localparam int AW    = $clog2(MAX_TEXT);
  localparam int EXT_W = AW + CALC_W;
  localparam int COL_LIMIT = (MAX_COLUMNS < KEY_ENTRIES) ? MAX_COLUMNS : KEY_ENTRIES;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // Configuration registers
  logic [COUNT_W-1:0] count_q;
  logic [LEN_W-1:0]   len_q;
  logic [KEY_W-1:0]   key_q;
  logic               enc_q;

  logic [2:0]         state_q, state_d;
  logic               use_rd_q, use_rd_d;
  logic               flag_q, flag_d;
  logic [CALC_W-1:0]  addr_q;
  logic               hit_q;
  logic               out_valid_q, out_valid_d;
  cct_out_t           out_data_q, out_data_d;

  logic               in_fire;
  logic [COUNT_W-1:0] cols;
  logic [CALC_W-1:0]  msg_len;
  logic               read_oor;
  logic               wr_in_store;
  logic [EXT_W-1:0]   pos_ext;
  logic [EXT_W-1:0]   addr_ext;
  logic [EXT_W-1:0]   rd_addr_ext;

  logic               div_start;
  logic [DIV_W-1:0]   div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   quo;
  logic [DIV_W-1:0]   rem;

  logic [KEY_ENT_W-1:0] key_ent [KEY_ENTRIES];
  logic [KEY_ENT_W-1:0] src;
  logic                 found;
  logic [LEN_W-1:0]     mul_a;
  logic [COUNT_W-1:0]   mul_b;
  logic [DIV_W-1:0]     mul_c;
  logic [CALC_W-1:0]    addr;
  logic                 hit;

  logic               wr_en;
  logic               rd_en;
  logic [CHAR_W-1:0]  rd_data;
  logic               load_out;

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COLUMN_COUNT_RST;
      len_q   <= COLUMN_LENGTH_RST;
      key_q   <= KEY_RST;
      enc_q   <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.reg_index)
        REG_COLUMN_COUNT:    count_q <= cfg_i.data.reg_data[COUNT_W-1:0];
        REG_COLUMN_LENGTH:   len_q   <= cfg_i.data.reg_data[LEN_W-1:0];
        REG_KEY_PERMUTATION: key_q   <= cfg_i.data.reg_data;
        REG_ENCRYPT_MODE:    enc_q   <= cfg_i.data.reg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Saturate the column count to the key size
  assign cols    = (count_q > COUNT_W'(COL_LIMIT)) ? COUNT_W'(COL_LIMIT) : count_q;
  assign msg_len = CALC_W'(cols) * CALC_W'(len_q);

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign pos_ext     = EXT_W'(in_i.data.position);
  assign wr_in_store = pos_ext < EXT_W'(MAX_TEXT);
  assign read_oor    = CALC_W'(in_i.data.position) >= msg_len;

  // Decrypt divides by the column count, encrypt by the column length
  assign div_start   = in_fire && (in_i.data.func == FUNC_READ) && !read_oor;
  assign div_divisor = enc_q ? len_q : DIV_W'(cols);

  cct_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (in_i.data.position),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  // ---------------------------------------------------------------- address
  always_comb begin
    for (int k = 0; k < KEY_ENTRIES; k++) begin
      key_ent[k] = key_q[KEY_ENT_W*k +: KEY_ENT_W];
    end
  end

  // Encrypt: last source column whose key entry names the output column
  always_comb begin
    found = 1'b0;
    src   = '0;
    for (int k = 0; k < KEY_ENTRIES; k++) begin
      if ((COUNT_W'(k) < cols) && (quo[DIV_W-1:KEY_ENT_W] == '0) &&
          (key_ent[k] == quo[KEY_ENT_W-1:0])) begin
        found = 1'b1;
        src   = KEY_ENT_W'(k);
      end
    end
  end

  // One multiply-add serves both modes
  assign mul_a    = enc_q ? rem : len_q;
  assign mul_b    = enc_q ? cols : COUNT_W'(key_ent[rem[KEY_ENT_W-1:0]]);
  assign mul_c    = enc_q ? DIV_W'(src) : quo;
  assign addr     = CALC_W'(mul_a) * CALC_W'(mul_b) + CALC_W'(mul_c);
  assign addr_ext = EXT_W'(addr);
  assign hit      = (addr_ext < EXT_W'(MAX_TEXT)) && (found || !enc_q);

  always_ff @(posedge clk_i) begin
    if (state_q == S_ADDR) begin
      addr_q <= addr;
      hit_q  <= hit;
    end
  end

  // ---------------------------------------------------------------- buffer
  assign wr_en       = in_fire && (in_i.data.func == FUNC_WRITE) && wr_in_store;
  assign rd_en       = (state_q == S_READ) && hit_q;
  assign rd_addr_ext = EXT_W'(addr_q);

  cct_store #(
    .Depth (MAX_TEXT),
    .AddrW (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (pos_ext[AW-1:0]),
    .wr_data_i (in_i.data.char_in),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr_ext[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // ---------------------------------------------------------------- sequencer
  assign load_out = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d  = state_q;
    use_rd_d = use_rd_q;
    flag_d   = flag_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          use_rd_d = 1'b0;
          if (in_i.data.func == FUNC_WRITE) begin
            flag_d  = !wr_in_store;
            state_d = S_DONE;
          end else if (read_oor) begin
            flag_d  = 1'b1;
            state_d = S_DONE;
          end else begin
            flag_d  = 1'b0;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        state_d = S_READ;
      end
      S_READ: begin
        use_rd_d = hit_q;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (load_out) begin
      out_valid_d             = 1'b1;
      out_data_d.char_out     = use_rd_q ? rd_data : '0;
      out_data_d.out_of_range = flag_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      use_rd_q    <= 1'b0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      use_rd_q    <= use_rd_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // ---------------------------------------------------------------- checks
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.out_of_range) |-> (out_o.data.char_out == '0))
    else $error("out-of-range result carries a non-zero byte");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (div_divisor != '0))
    else $error("divider started with a zero divisor");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  a_enc_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_ADDR) && enc_q) |-> (quo < DIV_W'(cols)))
    else $error("encrypt column index beyond column count");

endmodule

>>> rtl/cct_divider.sv
// ----------------------------------------------------------------------------
// cct_divider: iterative restoring divider
// Produces DIV_DIGITS quotient bits per cycle; result holds until next start.
// ----------------------------------------------------------------------------
module cct_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cct_pkg::DIV_W-1:0] dividend_i,
  input  logic [cct_pkg::DIV_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [cct_pkg::DIV_W-1:0] quotient_o,
  output logic [cct_pkg::DIV_W-1:0] remainder_o
);
  import cct_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIV_W-1:0]     divisor_q;
  logic [DIV_W-1:0]     step_rem;
  logic [DIV_W-1:0]     step_quo;
  logic                 last;

  assign last = (cnt_q == DIV_CNT_W'(DIV_ITER - 1));

  // Shift the dividend out MSB first while quotient bits shift in below
  always_comb begin
    logic [DIV_W:0] trial;
    step_rem = rem_q;
    step_quo = quo_q;
    for (int k = 0; k < DIV_DIGITS; k++) begin
      trial    = {step_rem, step_quo[DIV_W-1]};
      step_quo = {step_quo[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_q}) begin
        trial       = trial - {1'b0, divisor_q};
        step_quo[0] = 1'b1;
      end
      step_rem = trial[DIV_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = step_rem;
      quo_d = step_quo;
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      divisor_q <= divisor_i;
    end
  end

  assign done_o      = busy_q && last;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> rtl/cct_store.sv
// ----------------------------------------------------------------------------
// cct_store: text buffer
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cct_store #(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [cct_pkg::CHAR_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [AddrW-1:0]           rd_addr_i,
  output logic [cct_pkg::CHAR_W-1:0] rd_data_o
);
  import cct_pkg::*;

  logic [CHAR_W-1:0] mem_q [Depth];
  logic [CHAR_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> test/tb_columnar_transposition_cipher.sv
// ----------------------------------------------------------------------------
// tb_columnar_transposition_cipher: self-checking bench for the cipher engine
// Drives store writes and transposed reads through the request channel and
// register writes through the configuration channel. A behavioural copy of
// the engine predicts every result. Random gaps are put on the request side
// and random stalls on the result side. One long hold-off on the result side
// fills the engine and stalls its input.
// ----------------------------------------------------------------------------
module tb_columnar_transposition_cipher;
  import cct_pkg::*;

  localparam int MAX_TEXT     = 1024;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 600000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cct_cfg_if cfg_bus ();
  cct_in_if  req_bus ();
  cct_out_if res_bus ();

  columnar_transposition_cipher #(
    .MAX_TEXT(MAX_TEXT)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (req_bus),
    .out_o (res_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: register copies and the text image
  logic [COUNT_W-1:0] grid_cols   = COLUMN_COUNT_RST;
  logic [LEN_W-1:0]   grid_len    = COLUMN_LENGTH_RST;
  logic [KEY_W-1:0]   grid_key    = KEY_RST;
  logic               grid_encode = 1'b0;
  logic [CHAR_W-1:0]  text_image [MAX_TEXT];

  // Addresses that the stimulus has written at least once
  bit store_filled [MAX_TEXT];

  cct_out_t pending_results [$];
  int       mismatches    = 0;
  int       requests_sent = 0;
  int       cycle_count   = 0;
  int       sink_hold     = 0;
  int       stall_left    = 0;
  bit       source_gaps   = 1'b1;
  bit       sink_stalls   = 1'b1;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int active_columns();
    int c;
    c = int'(grid_cols);
    if (c > MAX_COLUMNS) c = MAX_COLUMNS;
    if (c > KEY_ENTRIES) c = KEY_ENTRIES;
    return c;
  endfunction

  function automatic int message_length();
    return active_columns() * int'(grid_len);
  endfunction

  function automatic int key_column(input int j);
    return int'(grid_key[KEY_ENT_W*j +: KEY_ENT_W]);
  endfunction

  // Store address behind an output position, or -1 for an out-of-range position or an unmatched encrypt column
  function automatic int source_address(input logic [POS_W-1:0] pos);
    int cols, len, p, col, src;
    bit found;
    cols  = active_columns();
    len   = int'(grid_len);
    p     = int'(pos);
    found = 1'b0;
    src   = 0;
    if (p >= cols * len) return -1;
    if (!grid_encode) return key_column(p % cols) * len + p / cols;
    col = p / len;
    // a repeated key entry resolves to its highest column
    for (int j = 0; j < cols; j++) begin
      if (key_column(j) == col) begin
        src   = j;
        found = 1'b1;
      end
    end
    if (!found) return -1;
    return (p % len) * cols + src;
  endfunction

  function automatic cct_out_t predict_response(input cct_in_t req);
    cct_out_t resp;
    int addr;
    resp = '0;
    if (req.func == FUNC_WRITE) begin
      if (int'(req.position) < MAX_TEXT) text_image[req.position] = req.char_in;
      else resp.out_of_range = 1'b1;
      return resp;
    end
    resp.out_of_range = int'(req.position) >= message_length();
    addr = source_address(req.position);
    if (addr >= 0 && addr < MAX_TEXT) resp.char_out = text_image[addr];
    return resp;
  endfunction

  function automatic logic [KEY_W-1:0] random_permutation_key();
    int order [KEY_ENTRIES];
    int t, tmp;
    logic [KEY_W-1:0] key;
    for (int k = 0; k < KEY_ENTRIES; k++) order[k] = k;
    for (int k = KEY_ENTRIES - 1; k > 0; k--) begin
      t        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[t];
      order[t] = tmp;
    end
    key = '0;
    for (int k = 0; k < KEY_ENTRIES; k++) key[KEY_ENT_W*k +: KEY_ENT_W] = KEY_ENT_W'(order[k]);
    return key;
  endfunction

  // Register copies follow each configuration transfer
  always @(posedge clk_i) begin
    if (rst_ni && cfg_bus.valid && cfg_bus.ready) begin
      case (cfg_bus.data.reg_index)
        REG_COLUMN_COUNT:    grid_cols   = cfg_bus.data.reg_data[COUNT_W-1:0];
        REG_COLUMN_LENGTH:   grid_len    = cfg_bus.data.reg_data[LEN_W-1:0];
        REG_KEY_PERMUTATION: grid_key    = cfg_bus.data.reg_data[KEY_W-1:0];
        REG_ENCRYPT_MODE:    grid_encode = cfg_bus.data.reg_data[0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && req_bus.valid && req_bus.ready)
      pending_results = {pending_results, predict_response(req_bus.data)};
  end

  always @(posedge clk_i) begin
    cct_out_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual char %02h range %0b",
                 $time, res_bus.data.char_out, res_bus.data.out_of_range);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (res_bus.data.char_out !== want.char_out) begin
          $display("%0t: char_out expected %02h actual %02h",
                   $time, want.char_out, res_bus.data.char_out);
          mismatches++;
        end
        if (res_bus.data.out_of_range !== want.out_of_range) begin
          $display("%0t: out_of_range expected %0b actual %0b",
                   $time, want.out_of_range, res_bus.data.out_of_range);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: a requested hold-off first, then random stalls when sink_stalls is set
  initial begin
    res_bus.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        res_bus.ready <= 1'b0;
        sink_hold--;
      end else if (stall_left > 0) begin
        res_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        res_bus.ready <= 1'b1;
        if (sink_stalls) stall_left = pick_gap();
      end
    end
  end

  // Keep valid high between back-to-back requests; return on the transfer
  task automatic send_request(input logic op, input logic [POS_W-1:0] pos,
                              input logic [CHAR_W-1:0] ch);
    cct_in_t req;
    int gap;
    gap          = source_gaps ? pick_gap() : 0;
    req.func     = op;
    req.position = pos;
    req.char_in  = ch;
    if (op == FUNC_WRITE) store_filled[pos] = 1'b1;
    @(negedge clk_i);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.data  <= req;
    do @(posedge clk_i); while (!req_bus.ready);
    requests_sent++;
  endtask

  // Write the source byte first if it has never been written
  task automatic read_position(input logic [POS_W-1:0] pos);
    int addr;
    addr = source_address(pos);
    if (addr >= 0 && addr < MAX_TEXT && !store_filled[addr])
      send_request(FUNC_WRITE, POS_W'(addr), CHAR_W'($urandom_range(0, 255)));
    send_request(FUNC_READ, pos, CHAR_W'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [KEY_W-1:0] value);
    cct_cfg_t wr;
    wr.reg_index = idx;
    wr.reg_data  = value;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= wr;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic apply_settings(input int cols, input int len,
                                input logic [KEY_W-1:0] key, input logic enc);
    wait_idle();
    write_register(REG_COLUMN_COUNT, KEY_W'(cols));
    write_register(REG_COLUMN_LENGTH, KEY_W'(len));
    write_register(REG_KEY_PERMUTATION, key);
    write_register(REG_ENCRYPT_MODE, KEY_W'(enc));
  endtask

  task automatic test_reset_defaults();
    send_request(FUNC_WRITE, 10'd0, 8'h00);
    send_request(FUNC_WRITE, 10'd1, 8'hFF);
    send_request(FUNC_WRITE, 10'd1023, 8'hA5);
    read_position(10'd0);
    read_position(10'd1);
    read_position(10'd2);
    read_position(10'd1023);
  endtask

  task automatic test_special_cases();
    // zero columns: every read out of range
    apply_settings(0, 1, KEY_RST, 1'b0);
    read_position(10'd0);
    // column count above the key size saturates at eight
    apply_settings(15, 1, KEY_RST, 1'b0);
    read_position(10'd7);
    read_position(10'd8);
    // zero length
    apply_settings(4, 0, KEY_RST, 1'b1);
    read_position(10'd0);
    // key entry past the columns points outside the store
    apply_settings(2, 512, KEY_RST | 24'h000038, 1'b0);
    read_position(10'd1);
    read_position(10'd0);
    // encrypt with a key that is not a permutation
    apply_settings(4, 2, '0, 1'b1);
    read_position(10'd0);
    read_position(10'd3);
    read_position(10'd8);
    apply_settings(8, 128, 24'hFFFFFF, 1'b1);
    read_position(10'd1023);
  endtask

  task automatic run_phase(input int phase);
    int cols, len, msg, budget, r;
    logic [KEY_W-1:0] key;
    logic enc;
    key = random_permutation_key();
    enc = 1'($urandom_range(0, 1));
    case (phase)
      0: begin cols = 8;  len = 512;  enc = 1'b0; end
      1: begin cols = 2;  len = 1;    enc = 1'b1; end
      2: begin cols = 15; len = 1023; key = KEY_W'($urandom); enc = 1'b1; end
      3: begin cols = 1;  len = 64;   enc = 1'b0; end
      default: begin
        r    = $urandom_range(0, 9);
        cols = (r < 8) ? $urandom_range(2, 8) : $urandom_range(0, 15);
        r    = $urandom_range(0, 9);
        if (r < 6)       len = $urandom_range(1, 16);
        else if (r < 8)  len = $urandom_range(17, 200);
        else if (r == 8) len = $urandom_range(0, 1) ? 0 : 512;
        else             len = $urandom_range(0, 1023);
        if ($urandom_range(0, 4) == 0) key = KEY_W'($urandom);
      end
    endcase
    source_gaps = (phase % 4 != 3);
    sink_stalls = source_gaps;
    apply_settings(cols, len, key, enc);
    msg = message_length();
    if (msg > MAX_TEXT) msg = MAX_TEXT;
    budget = $urandom_range(60, 140);
    // short messages: load the whole text, then read the full transform out
    if (msg > 0 && msg <= 64) begin
      for (int p = 0; p < msg; p++)
        send_request(FUNC_WRITE, POS_W'(p), CHAR_W'($urandom_range(0, 255)));
      for (int p = 0; p < msg; p++) read_position(POS_W'(p));
      budget -= 2 * msg;
    end
    while (budget > 0) begin
      r = $urandom_range(0, 99);
      if (r < 70 && msg > 0)
        read_position(POS_W'($urandom_range(0, msg - 1)));
      else if (r < 80)
        read_position(POS_W'($urandom_range(0, MAX_TEXT - 1)));
      else
        send_request(FUNC_WRITE, POS_W'($urandom_range(0, MAX_TEXT - 1)),
                     CHAR_W'($urandom_range(0, 255)));
      budget--;
    end
  endtask

  task automatic test_random_phases();
    int phase, target;
    phase  = 0;
    target = requests_sent + RANDOM_ITEMS;
    while (requests_sent < target) begin
      run_phase(phase);
      phase++;
    end
  endtask

  task automatic test_backpressure();
    apply_settings(4, 8, random_permutation_key(), 1'b0);
    source_gaps = 1'b0;
    sink_stalls = 1'b1;
    sink_hold   = 300;
    repeat (24) read_position(POS_W'($urandom_range(0, 31)));
  endtask

  initial begin
    cfg_bus.valid = 1'b0;
    cfg_bus.data  = '0;
    req_bus.valid = 1'b0;
    req_bus.data  = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_special_cases();
    test_random_phases();
    test_backpressure();
    wait_idle();
    repeat (12) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
